// ----- rtl/mjph_pkg.sv -----
// Shared types and constants of the multi-joint PID hold block.
`timescale 1ns / 1ps
package mjph_pkg;

    localparam int MAX_JOINTS = 4;
    localparam int GAIN_W     = 16;
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 17;
    localparam int TIME_W     = 32;
    localparam int INTEG_W    = 48;
    localparam int PROD_W     = 50;
    localparam int ACCSUM_W   = 51;
    localparam int PTERM_W    = 33;
    localparam int DTERM_W    = 32;
    localparam int KI_HALF_W  = 24;
    localparam int KILO_W     = 41;
    localparam int KIHI_W     = 40;
    localparam int SUM_W      = 66;
    localparam int ACCEL_W    = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        OP_EVAL   = 2'd0,
        OP_HOLD   = 2'd1,
        OP_IDLE   = 2'd2,
        OP_SETREF = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP  = 2'd0,
        REG_INTEG = 2'd1,
        REG_DERIV = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_KI,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic run;
        logic ld_err;
        logic ld_ref;
        logic clr_integ;
        logic ld_mul;
        logic ld_acc;
        logic ld_ki;
        logic ld_sum;
    } t_lane_ctl;

    typedef logic signed [ACCEL_W-1:0] t_accel;

endpackage

// ----- rtl/mjph_lane.sv -----
// One joint's PID core: error, integral, three gain products and output scaling.
`timescale 1ns / 1ps
module mjph_lane (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mjph_pkg::t_lane_ctl                     i_ctl,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]     i_value,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]     i_velocity,
    input  logic signed [mjph_pkg::GAIN_W-1:0]      i_kp,
    input  logic signed [mjph_pkg::GAIN_W-1:0]      i_ki,
    input  logic signed [mjph_pkg::GAIN_W-1:0]      i_kd,
    input  logic        [mjph_pkg::TIME_W-1:0]      i_dt,
    output mjph_pkg::t_accel                        o_accel
);
    import mjph_pkg::*;

    logic signed [ANGLE_W-1:0]  r_ref;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [ANGLE_W-1:0]  r_vel;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PTERM_W-1:0]  r_pterm;
    logic signed [DTERM_W-1:0]  r_dterm;
    logic signed [KILO_W-1:0]   r_kilo;
    logic signed [KIHI_W-1:0]   r_kihi;
    logic signed [SUM_W-1:0]    r_sum;

    logic signed [ERR_W-1:0]    n_err;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [PTERM_W-1:0]  n_pterm;
    logic signed [DTERM_W-1:0]  n_dterm;
    logic signed [ACCSUM_W-1:0] w_accsum;
    logic signed [INTEG_W-1:0]  n_integ;
    logic signed [KILO_W-1:0]   n_kilo;
    logic signed [KIHI_W-1:0]   n_kihi;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    w_neg;
    logic signed [SUM_W-1:0]    w_shr;

    always_comb begin
        n_err   = $signed({i_value[ANGLE_W-1], i_value}) - $signed({r_ref[ANGLE_W-1], r_ref});
        n_prod  = PROD_W'(r_err * $signed({1'b0, i_dt}));
        n_pterm = PTERM_W'(i_kp * r_err);
        n_dterm = DTERM_W'(i_kd * r_vel);

        w_accsum = ACCSUM_W'(r_integ) + ACCSUM_W'(r_prod);
        if (w_accsum[ACCSUM_W-1:INTEG_W-1] == '0 || w_accsum[ACCSUM_W-1:INTEG_W-1] == '1) begin
            n_integ = w_accsum[INTEG_W-1:0];
        end else if (w_accsum[ACCSUM_W-1]) begin
            n_integ = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            n_integ = {1'b0, {(INTEG_W-1){1'b1}}};
        end

        n_kilo = KILO_W'(i_ki * $signed({1'b0, r_integ[KI_HALF_W-1:0]}));
        n_kihi = KIHI_W'(i_ki * $signed(r_integ[INTEG_W-1:KI_HALF_W]));

        n_sum = (SUM_W'(r_kihi) <<< KI_HALF_W) + SUM_W'(r_kilo)
              + SUM_W'(r_pterm) + (SUM_W'(r_dterm) <<< 2);

        w_neg = -r_sum;
        w_shr = w_neg >>> 8;
        if (w_shr[SUM_W-1:ACCEL_W-1] == '0 || w_shr[SUM_W-1:ACCEL_W-1] == '1) begin
            o_accel = w_shr[ACCEL_W-1:0];
        end else if (w_shr[SUM_W-1]) begin
            o_accel = {1'b1, {(ACCEL_W-1){1'b0}}};
        end else begin
            o_accel = {1'b0, {(ACCEL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= '0;
            r_integ <= '0;
        end else begin
            if (i_ctl.ld_ref) begin
                r_ref <= i_value;
            end
            if (i_ctl.clr_integ) begin
                r_integ <= '0;
            end else if (i_ctl.ld_acc && i_ctl.run) begin
                r_integ <= n_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_err) begin
            r_err <= n_err;
            r_vel <= i_velocity;
        end
        if (i_ctl.ld_mul) begin
            r_prod  <= n_prod;
            r_pterm <= n_pterm;
            r_dterm <= n_dterm;
        end
        if (i_ctl.ld_ki) begin
            r_kilo <= n_kilo;
            r_kihi <= n_kihi;
        end
        if (i_ctl.ld_sum) begin
            r_sum <= n_sum;
        end
    end

endmodule

// ----- rtl/mjph_merge.sv -----
// Output stage: gathers lane results into one output word register.
`timescale 1ns / 1ps
module mjph_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_run,
    input  logic              i_hold,
    input  mjph_pkg::t_accel  i_accel [mjph_pkg::MAX_JOINTS],
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output mjph_pkg::t_accel  o_accel [mjph_pkg::MAX_JOINTS],
    output logic              o_command_valid,
    output logic              o_holding
);
    import mjph_pkg::*;

    logic   r_valid;
    t_accel r_accel [MAX_JOINTS];
    logic   r_cmd;
    logic   r_hold;

    assign o_ready         = !r_valid || !i_stall;
    assign o_valid         = r_valid;
    assign o_command_valid = r_cmd;
    assign o_holding       = r_hold;

    always_comb begin
        for (int j = 0; j < MAX_JOINTS; j++) begin
            o_accel[j] = r_accel[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < MAX_JOINTS; j++) begin
                r_accel[j] <= i_run ? i_accel[j] : '0;
            end
            r_cmd  <= i_run;
            r_hold <= i_hold;
        end
    end

endmodule

// ----- rtl/multi_joint_pid_hold_top.sv -----
// Top level of the multi-joint PID hold block: control sequencer, gains and lanes.
//
//   port group     dir   handshake            contents
//   input word     in    i_valid / o_stall    operation, tick time, positions, velocities
//   output word    out   o_valid / i_stall    accelerations, command valid, holding
//   config write   in    i_cfg_we             index 0 prop, 1 integ, 2 deriv gains
//
// The error is captured at the accepting edge; the output register loads after the
// multiply, integral, integral-gain product and sum steps, once the output register is ready.
// One word is in flight at a time; o_stall is high while the sequencer is busy or in reset,
// so no new word is accepted until the last one has been loaded into the output register.
// A finished word waits in the output register; the next word may enter meanwhile.
// Reset clears hold state, references, integrals and gains; no clearing pass.
`timescale 1ns / 1ps
module multi_joint_pid_hold_top #(
    parameter int NUM_JOINTS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_operation,
    input  logic [mjph_pkg::TIME_W-1:0]           i_tick_time,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_value_0,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_value_1,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_value_2,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_value_3,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_velocity_0,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_velocity_1,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_velocity_2,
    input  logic signed [mjph_pkg::ANGLE_W-1:0]   i_velocity_3,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [mjph_pkg::ACCEL_W-1:0]   o_accel_0,
    output logic signed [mjph_pkg::ACCEL_W-1:0]   o_accel_1,
    output logic signed [mjph_pkg::ACCEL_W-1:0]   o_accel_2,
    output logic signed [mjph_pkg::ACCEL_W-1:0]   o_accel_3,
    output logic                                  o_command_valid,
    output logic                                  o_holding,
    input  logic                                  i_cfg_we,
    input  logic [mjph_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mjph_pkg::CFG_W-1:0]            i_cfg_data
);
    import mjph_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_prop;
    logic [CFG_W-1:0]    r_integ_gain;
    logic [CFG_W-1:0]    r_deriv;
    logic                r_hold;
    logic                r_time_seen;
    logic [TIME_W-1:0]   r_prev_time;
    logic [TIME_W-1:0]   r_dt;
    logic                r_run;

    logic                w_accept;
    logic                w_load;
    logic                w_out_ready;
    t_op                 w_op;
    t_lane_ctl           w_ctl;
    logic signed [ANGLE_W-1:0] w_value [MAX_JOINTS];
    logic signed [ANGLE_W-1:0] w_vel   [MAX_JOINTS];
    t_accel              w_lane_accel [MAX_JOINTS];
    t_accel              w_out_accel  [MAX_JOINTS];

    assign w_op     = t_op'(i_operation);
    assign o_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept = i_valid && !o_stall;

    assign w_value[0] = i_value_0;
    assign w_value[1] = i_value_1;
    assign w_value[2] = i_value_2;
    assign w_value[3] = i_value_3;
    assign w_vel[0]   = i_velocity_0;
    assign w_vel[1]   = i_velocity_1;
    assign w_vel[2]   = i_velocity_2;
    assign w_vel[3]   = i_velocity_3;

    always_comb begin
        w_ctl.run       = r_run;
        w_ctl.ld_err    = w_accept && (w_op == OP_EVAL);
        w_ctl.ld_ref    = w_accept && (w_op == OP_HOLD || w_op == OP_SETREF);
        w_ctl.clr_integ = w_accept && (w_op == OP_HOLD);
        w_ctl.ld_mul    = (r_state == ST_MUL);
        w_ctl.ld_acc    = (r_state == ST_ACC);
        w_ctl.ld_ki     = (r_state == ST_KI);
        w_ctl.ld_sum    = (r_state == ST_SUM);
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = ST_KI;
            ST_KI:  n_state = ST_SUM;
            ST_SUM: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop       <= '0;
            r_integ_gain <= '0;
            r_deriv      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROP:  r_prop       <= i_cfg_data;
                REG_INTEG: r_integ_gain <= i_cfg_data;
                REG_DERIV: r_deriv      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= 1'b0;
            r_time_seen <= 1'b0;
            r_prev_time <= '0;
            r_run       <= 1'b0;
        end else if (w_accept) begin
            r_run <= (w_op == OP_EVAL) && r_hold;
            case (w_op)
                OP_HOLD: begin
                    r_hold      <= 1'b1;
                    r_time_seen <= 1'b0;
                end
                OP_IDLE: r_hold <= 1'b0;
                OP_SETREF: ;
                OP_EVAL: begin
                    if (r_hold) begin
                        r_time_seen <= 1'b1;
                        r_prev_time <= i_tick_time;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == OP_EVAL) begin
            r_dt <= r_time_seen ? (i_tick_time - r_prev_time) : '0;
        end
    end

    for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
        if (j < NUM_JOINTS) begin : g_on
            mjph_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_value    (w_value[j]),
                .i_velocity (w_vel[j]),
                .i_kp       ($signed(r_prop[GAIN_W*j +: GAIN_W])),
                .i_ki       ($signed(r_integ_gain[GAIN_W*j +: GAIN_W])),
                .i_kd       ($signed(r_deriv[GAIN_W*j +: GAIN_W])),
                .i_dt       (r_dt),
                .o_accel    (w_lane_accel[j])
            );
        end else begin : g_off
            assign w_lane_accel[j] = '0;
        end
    end

    mjph_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .i_run           (r_run),
        .i_hold          (r_hold),
        .i_accel         (w_lane_accel),
        .i_stall         (i_stall),
        .o_ready         (w_out_ready),
        .o_valid         (o_valid),
        .o_accel         (w_out_accel),
        .o_command_valid (o_command_valid),
        .o_holding       (o_holding)
    );

    assign o_accel_0 = w_out_accel[0];
    assign o_accel_1 = w_out_accel[1];
    assign o_accel_2 = w_out_accel[2];
    assign o_accel_3 = w_out_accel[3];

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_MUL)
        else $error("accepted word did not start the sequence");

    a_cmd_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_command_valid |-> o_holding)
        else $error("command word while not holding");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_state == ST_OUT && !(o_valid && i_stall))
        else $error("output loaded outside the final stage");

    a_hold_clears_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_op == OP_HOLD |=> r_hold && !r_time_seen)
        else $error("hold did not mark time unseen");

endmodule
